// ===== hw/rtl/ysf_pkg.sv =====
package ysf_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned CmdQueueDepth = 4;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0] CharSoh = 8'h01;
  localparam logic [7:0] CharAck = 8'h06;
  localparam logic [7:0] CharNak = 8'h15;
  localparam logic [7:0] CharEot = 8'h04;
  localparam logic [7:0] CharCee = 8'h43;

  typedef enum logic [1:0] {
    ActReply = 2'd0,
    ActName  = 2'd1,
    ActData  = 2'd2,
    ActEof   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StNormal  = 2'd0,
    StFail    = 2'd1,
    StDone    = 2'd2,
    StIgnored = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    PhIdle    = 10'b0000000001,
    PhName    = 10'b0000000010,
    PhHdrAck  = 10'b0000000100,
    PhHdrC    = 10'b0000001000,
    PhData    = 10'b0000010000,
    PhDataAck = 10'b0000100000,
    PhEot1Nak = 10'b0001000000,
    PhEot2Ack = 10'b0010000000,
    PhEot2C   = 10'b0100000000,
    PhEndAck  = 10'b1000000000
  } phase_e;

  // Operation handed from the front part to the back part.
  typedef enum logic [2:0] {
    OpStatus = 3'd0,
    OpOpen   = 3'd1,
    OpBody   = 3'd2,
    OpClose  = 3'd3,
    OpEot    = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    status_e    status;
    logic       last;
  } cmd_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ysf_front.sv =====
module ysf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         reply_byte_i,
  input  logic [7:0]         payload_byte_i,
  input  logic               chunk_last_i,
  output logic               cmd_valid_o,
  output ysf_pkg::cmd_t      cmd_o,
  input  logic               cmd_ready_i
);
  import ysf_pkg::*;

  localparam int unsigned NameMax = BlockBytes - 5;

  typedef enum logic [3:0] {
    SeqIdle  = 4'b0001,
    SeqList  = 4'b0010,
    SeqPad   = 4'b0100,
    SeqSize  = 4'b1000
  } seq_e;

  logic [31:0] size_q;
  phase_e phase_q, phase_d;
  seq_e seq_q, seq_d;
  logic [7:0] bseq_q, bseq_d;
  logic [7:0] fill_q, fill_d;
  logic open_q, open_d;
  logic [1:0] sz_q, sz_d;
  // Up to three queued commands built from one input item.
  cmd_t list_q [3];
  cmd_t list_d [3];
  logic [1:0] lcnt_q, lcnt_d;
  logic [1:0] lidx_q, lidx_d;
  logic       name_last_q, name_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= '0;
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  assign full_o = (seq_q != SeqIdle);

  function automatic cmd_t mk(op_e op, logic [7:0] d, status_e s, logic l);
    cmd_t c;
    c.op = op;
    c.data = d;
    c.status = s;
    c.last = l;
    return c;
  endfunction

  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o = mk(OpStatus, 8'h00, StNormal, 1'b1);
    unique case (seq_q)
      SeqList: begin
        cmd_valid_o = 1'b1;
        cmd_o = list_q[lidx_q];
      end
      SeqSize: begin
        cmd_valid_o = 1'b1;
        unique case (sz_q)
          2'd0: cmd_o = mk(OpBody, size_q[31:24], StNormal, 1'b0);
          2'd1: cmd_o = mk(OpBody, size_q[23:16], StNormal, 1'b0);
          2'd2: cmd_o = mk(OpBody, size_q[15:8], StNormal, 1'b0);
          default: cmd_o = mk(OpBody, size_q[7:0], StNormal, 1'b0);
        endcase
      end
      SeqPad: begin
        cmd_valid_o = 1'b1;
        cmd_o = mk(OpClose, 8'h00, StNormal, 1'b1);
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    seq_d = seq_q;
    bseq_d = bseq_q;
    fill_d = fill_q;
    open_d = open_q;
    sz_d = sz_q;
    list_d = list_q;
    lcnt_d = lcnt_q;
    lidx_d = lidx_q;
    name_last_d = name_last_q;
    unique case (seq_q)
      SeqIdle: begin
        if (push_i) begin
          lidx_d = 2'd0;
          lcnt_d = 2'd1;
          list_d[0] = mk(OpStatus, 8'h00, StIgnored, 1'b1);
          list_d[1] = mk(OpStatus, 8'h00, StNormal, 1'b1);
          list_d[2] = mk(OpStatus, 8'h00, StNormal, 1'b1);
          name_last_d = 1'b0;
          seq_d = SeqList;
          unique case (action_e'(action_i))
            ActReply: begin
              priority case (phase_q)
                PhIdle: if (reply_byte_i == CharCee) begin
                  list_d[0] = mk(OpStatus, 8'h00, StNormal, 1'b1);
                  phase_d = PhName; bseq_d = '0; fill_d = '0; open_d = 1'b0;
                end
                PhHdrAck, PhHdrC, PhDataAck, PhEot2Ack, PhEot1Nak, PhEot2C,
                PhEndAck: begin
                  logic [7:0] want;
                  want = (phase_q == PhHdrC || phase_q == PhEot2C) ? CharCee :
                         (phase_q == PhEot1Nak) ? CharNak : CharAck;
                  if (reply_byte_i != want) begin
                    list_d[0] = mk(OpStatus, 8'h00, StFail, 1'b1);
                    phase_d = PhIdle; bseq_d = '0; fill_d = '0; open_d = 1'b0;
                  end else begin
                    list_d[0] = mk(OpStatus, 8'h00, StNormal, 1'b1);
                    priority case (phase_q)
                      PhHdrAck: phase_d = PhHdrC;
                      PhHdrC, PhDataAck: phase_d = PhData;
                      PhEot1Nak: begin
                        list_d[0] = mk(OpEot, 8'h00, StNormal, 1'b1);
                        phase_d = PhEot2Ack;
                      end
                      PhEot2Ack: phase_d = PhEot2C;
                      PhEot2C: begin
                        list_d[0] = mk(OpOpen, 8'h00, StNormal, 1'b0);
                        list_d[1] = mk(OpClose, 8'h00, StNormal, 1'b1);
                        lcnt_d = 2'd2;
                        bseq_d = '0;
                        phase_d = PhEndAck;
                      end
                      default: begin
                        list_d[0] = mk(OpStatus, 8'h00, StDone, 1'b1);
                        phase_d = PhIdle; bseq_d = '0; fill_d = '0; open_d = 1'b0;
                      end
                    endcase
                  end
                end
                default: ;
              endcase
            end
            ActName: begin
              if (phase_q == PhName) begin
                logic [1:0] n;
                n = 2'd0;
                if (!open_q) begin
                  list_d[0] = mk(OpOpen, 8'h00, StNormal, 1'b0);
                  n = 2'd1;
                  open_d = 1'b1;
                  bseq_d = '0;
                end
                if (32'(open_q ? fill_q : 8'd0) < NameMax) begin
                  list_d[n] = mk(OpBody, payload_byte_i, StNormal, ~chunk_last_i);
                  n = n + 2'd1;
                  fill_d = (open_q ? fill_q : 8'd0) + 8'd1;
                end else if (!chunk_last_i) begin
                  list_d[n] = mk(OpStatus, 8'h00, StIgnored, 1'b1);
                  n = n + 2'd1;
                end
                if (chunk_last_i) begin
                  list_d[n] = mk(OpBody, 8'h00, StNormal, 1'b0);
                  n = n + 2'd1;
                  name_last_d = 1'b1;
                  open_d = 1'b0;
                  fill_d = '0;
                  phase_d = PhHdrAck;
                end
                lcnt_d = n;
              end
            end
            ActData: begin
              if (phase_q == PhData) begin
                logic [1:0] n;
                logic [7:0] f;
                logic cl;
                n = 2'd0;
                if (!open_q) begin
                  list_d[0] = mk(OpOpen, bseq_q + 8'd1, StNormal, 1'b0);
                  bseq_d = bseq_q + 8'd1;
                  n = 2'd1;
                end
                f = (open_q ? fill_q : 8'd0) + 8'd1;
                cl = chunk_last_i || (32'(f) >= BlockBytes);
                list_d[n] = mk(OpBody, payload_byte_i, StNormal, ~cl);
                n = n + 2'd1;
                if (cl) begin
                  list_d[n] = mk(OpClose, 8'h00, StNormal, 1'b1);
                  n = n + 2'd1;
                  open_d = 1'b0; fill_d = '0; phase_d = PhDataAck;
                end else begin
                  open_d = 1'b1; fill_d = f;
                end
                lcnt_d = n;
              end
            end
            default: begin
              if (phase_q == PhData) begin
                if (open_q) begin
                  list_d[0] = mk(OpClose, 8'h00, StNormal, 1'b1);
                  open_d = 1'b0; fill_d = '0; phase_d = PhDataAck;
                end else begin
                  list_d[0] = mk(OpEot, 8'h00, StNormal, 1'b1);
                  phase_d = PhEot1Nak;
                end
              end
            end
          endcase
        end
      end
      SeqList: begin
        if (cmd_ready_i) begin
          if (lidx_q + 2'd1 == lcnt_q) begin
            if (name_last_q) begin
              seq_d = SeqSize;
              sz_d = 2'd0;
            end else begin
              seq_d = SeqIdle;
            end
          end else begin
            lidx_d = lidx_q + 2'd1;
          end
        end
      end
      SeqSize: begin
        if (cmd_ready_i) begin
          sz_d = sz_q + 2'd1;
          if (sz_q == 2'd3) seq_d = SeqPad;
        end
      end
      default: begin
        if (cmd_ready_i) seq_d = SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      seq_q <= SeqIdle;
      bseq_q <= '0;
      fill_q <= '0;
      open_q <= 1'b0;
      sz_q <= '0;
      lcnt_q <= '0;
      lidx_q <= '0;
      name_last_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      seq_q <= seq_d;
      bseq_q <= bseq_d;
      fill_q <= fill_d;
      open_q <= open_d;
      sz_q <= sz_d;
      lcnt_q <= lcnt_d;
      lidx_q <= lidx_d;
      name_last_q <= name_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
  end

endmodule

// ===== hw/rtl/ysf_cmd_fifo.sv =====
module ysf_cmd_fifo #(
  parameter int unsigned Depth = ysf_pkg::CmdQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  ysf_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output ysf_pkg::cmd_t rd_data_o
);
  import ysf_pkg::*;

  localparam int unsigned AW = $clog2(Depth);

  cmd_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// ===== hw/rtl/ysf_back.sv =====
module ysf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ysf_pkg::cmd_t cmd_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    send_byte_o,
  output logic [7:0]    repeat_count_o,
  output logic          frame_end_o,
  output logic [1:0]    status_o,
  output logic          run_last_o
);
  import ysf_pkg::*;

  typedef enum logic [6:0] {
    BkIdle  = 7'b0000001,
    BkSeq   = 7'b0000010,
    BkInv   = 7'b0000100,
    BkPad   = 7'b0001000,
    BkPadRn = 7'b0010000,
    BkCrcHi = 7'b0100000,
    BkCrcLo = 7'b1000000
  } bk_e;

  bk_e st_q, st_d;
  logic [7:0] seq_q, seq_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0] fill_q, fill_d;
  logic [7:0] pad_q, pad_d;
  logic       last_q, last_d;
  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d, oc_q, oc_d;
  logic       ofe_q, ofe_d, orl_q, orl_d;
  logic [1:0] os_q, os_d;
  logic       out_free;

  assign out_free = !ov_q || pop_i;
  assign empty_o = !ov_q;
  assign send_byte_o = ob_q;
  assign repeat_count_o = oc_q;
  assign frame_end_o = ofe_q;
  assign status_o = os_q;
  assign run_last_o = orl_q;
  assign cmd_ready_o = (st_q == BkIdle) && out_free;

  always_comb begin
    st_d = st_q; seq_d = seq_q; crc_d = crc_q; fill_d = fill_q;
    pad_d = pad_q; last_d = last_q;
    ov_d = ov_q && !pop_i;
    ob_d = ob_q; oc_d = oc_q; ofe_d = ofe_q; os_d = os_q; orl_d = orl_q;
    unique case (st_q)
      BkIdle: begin
        if (cmd_valid_i && out_free) begin
          last_d = cmd_i.last;
          unique case (cmd_i.op)
            OpStatus: begin
              ov_d = 1'b1; ob_d = '0; oc_d = '0; ofe_d = 1'b0;
              os_d = cmd_i.status; orl_d = cmd_i.last;
            end
            OpOpen: begin
              ov_d = 1'b1; ob_d = CharSoh; oc_d = 8'd1; ofe_d = 1'b0;
              os_d = StNormal; orl_d = 1'b0;
              seq_d = cmd_i.data; crc_d = '0; fill_d = '0;
              st_d = BkSeq;
            end
            OpBody: begin
              ov_d = 1'b1; ob_d = cmd_i.data; oc_d = 8'd1; ofe_d = 1'b0;
              os_d = StNormal; orl_d = cmd_i.last;
              crc_d = crc_byte(crc_q, cmd_i.data);
              fill_d = fill_q + 8'd1;
            end
            OpClose: begin
              pad_d = 8'(BlockBytes) - fill_q;
              st_d = (fill_q < 8'(BlockBytes)) ? BkPad : BkCrcHi;
            end
            default: begin
              ov_d = 1'b1; ob_d = CharEot; oc_d = 8'd1; ofe_d = 1'b1;
              os_d = StNormal; orl_d = cmd_i.last;
            end
          endcase
        end
      end
      BkSeq: if (out_free) begin
        ov_d = 1'b1; ob_d = seq_q; oc_d = 8'd1; orl_d = 1'b0;
        st_d = BkInv;
      end
      BkInv: if (out_free) begin
        ov_d = 1'b1; ob_d = ~seq_q; oc_d = 8'd1; orl_d = last_q;
        st_d = BkIdle;
      end
      BkPad: begin
        crc_d = crc_byte(crc_q, 8'h00);
        fill_d = fill_q + 8'd1;
        if (fill_q == 8'(BlockBytes - 1)) st_d = BkPadRn;
      end
      BkPadRn: if (out_free) begin
        ov_d = 1'b1; ob_d = 8'h00; oc_d = pad_q; ofe_d = 1'b0;
        os_d = StNormal; orl_d = 1'b0;
        st_d = BkCrcHi;
      end
      BkCrcHi: if (out_free) begin
        ov_d = 1'b1; ob_d = crc_q[15:8]; oc_d = 8'd1; ofe_d = 1'b0;
        os_d = StNormal; orl_d = 1'b0;
        st_d = BkCrcLo;
      end
      default: if (out_free) begin
        ov_d = 1'b1; ob_d = crc_q[7:0]; oc_d = 8'd1; ofe_d = 1'b1;
        os_d = StNormal; orl_d = last_q; fill_d = '0;
        st_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      ov_q <= 1'b0;
      fill_q <= '0;
      crc_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      fill_q <= fill_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d; pad_q <= pad_d; last_q <= last_d;
    ob_q <= ob_d; oc_q <= oc_d; ofe_q <= ofe_d; os_q <= os_d; orl_q <= orl_d;
  end

endmodule

// ===== hw/rtl/ymodem_sender_framer.sv =====
// YMODEM sender framer. Push one item per action (receiver reply, name byte,
// data byte or end of file); pop the resulting byte runs, each with a repeat
// count, frame end flag and status, run_last marking the last of the item.
// The front part takes a new item only once all commands of the last one
// are queued. An item that closes a block also runs the CRC unit over each
// zero pad byte before the pad run is output; a command queue between the
// front and back parts lets input and output stall independently.
module ymodem_sender_framer #(
  parameter int unsigned QueueDepth = ysf_pkg::CmdQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  reply_byte_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        chunk_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  send_byte_o,
  output logic [7:0]  repeat_count_o,
  output logic        frame_end_o,
  output logic [1:0]  status_o,
  output logic        run_last_o
);
  import ysf_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  ysf_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .push_i(push), .full_o(full),
    .action_i, .reply_byte_i, .payload_byte_i, .chunk_last_i,
    .cmd_valid_o(f_valid), .cmd_o(f_cmd), .cmd_ready_i(f_ready)
  );

  ysf_cmd_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  ysf_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .empty_o(empty), .pop_i(pop),
    .send_byte_o, .repeat_count_o, .frame_end_o, .status_o, .run_last_o
  );

endmodule

// ===== hw/rtl/ysf_checker.sv =====
module ysf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] send_byte_o,
  input logic [7:0] repeat_count_o,
  input logic       frame_end_o,
  input logic [1:0] status_o,
  input logic       run_last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(send_byte_o) && $stable(status_o)))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (repeat_count_o <= 8'd128))
    else $error("repeat count out of range");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != 2'd0) |-> (repeat_count_o == 8'd0 && run_last_o))
    else $error("status result not alone");

  a_fe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> (repeat_count_o == 8'd1))
    else $error("frame end on a run");

endmodule

bind ymodem_sender_framer ysf_checker u_ysf_checker (
  .clk_i, .rst_ni, .empty, .pop, .send_byte_o, .repeat_count_o,
  .frame_end_o, .status_o, .run_last_o
);
